[rtl/grs_pkg.sv]
// shared widths, codes and defaults of the grouped reservoir sampler
`timescale 1ns / 1ps

package grs_pkg;

    localparam int GROUP_W     = 11;
    localparam int GROUP_EXT_W = 17;
    localparam int SLOT_IDX_W  = 6;
    localparam int SAMPLE_W    = 64;
    localparam int RANDOM_W    = 31;
    localparam int COUNT_W     = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 32'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

    localparam int DEF_GROUP_COUNT     = 1024;
    localparam int DEF_RESERVOIR_SLOTS = 4;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

[rtl/grs_if.sv]
// valid/ready channel interfaces for input items and result words
`timescale 1ns / 1ps

interface grs_item_if
    import grs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic [GROUP_W-1:0]         group_number;
    logic                       start_group;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [RANDOM_W-1:0]        random_word;

    modport source (
        output valid, operation, group_number, start_group, sample_value, random_word,
        input  ready
    );
    modport sink (
        input  valid, operation, group_number, start_group, sample_value, random_word,
        output ready
    );
endinterface

interface grs_result_if
    import grs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [GROUP_W-1:0]         group_echo;
    logic [SLOT_IDX_W-1:0]      slot_index;
    logic signed [SAMPLE_W-1:0] slot_value;
    logic                       last_result;

    modport source (
        output valid, group_echo, slot_index, slot_value, last_result,
        input  ready
    );
    modport sink (
        input  valid, group_echo, slot_index, slot_value, last_result,
        output ready
    );
endinterface

[rtl/grs_rem.sv]
// bit-serial remainder of the random word by the running count
`timescale 1ns / 1ps

module grs_rem
    import grs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RANDOM_W-1:0] dividend,
    input  logic [COUNT_W-1:0]  divisor,
    output logic                done,
    output logic [COUNT_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(RANDOM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RANDOM_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [RANDOM_W-1:0] dvd_reg, dvd_next;
    logic [COUNT_W-1:0]  dsr_reg, dsr_next;
    logic [COUNT_W:0]    trial;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[RANDOM_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = COUNT_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[COUNT_W-1:0];
            end
            dvd_next = {dvd_reg[RANDOM_W-2:0], 1'b0};
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[rtl/grouped_reservoir_sampler_top.sv]
// grouped reservoir sampler: group table memory, sequencer and result register
`timescale 1ns / 1ps
//
// usage
//   items: one word per request. operation add offers sample_value to the
//     group given by group_number (one-based); start_group restarts that
//     group's count at 1 first. operation read streams the group's slots
//   results: an add gives one word (group echo, slot 0, value 0, last set);
//     a read gives RESERVOIR_SLOTS words, slot 0 upward, last on the final one
//   groups outside 1..GROUP_COUNT change nothing and read back as zeros
// sequence
//   one item at a time; the sequencer is set by the group table's registered
//   read and its read-modify-write of the row
//   add into a reservoir that is not yet full: lookup, then write-back and result
//   add into a full reservoir: lookup, a wait on the one-bit-per-cycle
//     remainder unit (31 steps and its done flag), then write-back and result
//   read: lookup, then the slot words in order, held while the receiver stalls
// reset
//   a clearing pass writes count 1 and zero samples into every row;
//   items.ready stays low until it ends
// stall
//   results sit in an output register; the next item is accepted while the
//   final word of the previous one still waits, and a stalled receiver holds
//   the sequencer at its next result
module grouped_reservoir_sampler_top
    import grs_pkg::*;
#(
    parameter int GROUP_COUNT     = DEF_GROUP_COUNT,
    parameter int RESERVOIR_SLOTS = DEF_RESERVOIR_SLOTS
)
(
    input  logic  clk,
    input  logic  rst_n,
    grs_item_if.sink     items,
    grs_result_if.source results
);

    localparam int GW     = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int SLOT_W = (RESERVOIR_SLOTS > 1) ? $clog2(RESERVOIR_SLOTS) : 1;
    localparam int ROW_W  = COUNT_W + SAMPLE_W * RESERVOIR_SLOTS;

    localparam logic [GW-1:0]      GROUP_LAST = GW'(GROUP_COUNT - 1);
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(RESERVOIR_SLOTS - 1);
    localparam logic [COUNT_W-1:0] SLOTS_CNT  = COUNT_W'(RESERVOIR_SLOTS);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_LOOK   = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_ADD_WB = 6'b010000,
        ST_RD_OUT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // group table: one row per group, count in the low bits, then the slots
    logic [ROW_W-1:0] group_ram [GROUP_COUNT];
    logic [ROW_W-1:0] rd_row_reg;
    logic             mem_we;
    logic [GW-1:0]    mem_wa;
    logic [ROW_W-1:0] mem_wd;
    logic             mem_re;
    logic [GW-1:0]    mem_ra;

    // latched item
    logic                       op_reg;
    logic [GROUP_W-1:0]         grp_reg;
    logic                       start_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [RANDOM_W-1:0]        rnd_reg;
    logic                       item_valid_reg;
    logic [GW-1:0]              gidx_reg;

    logic [GW-1:0]       clr_ptr_reg, clr_ptr_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [SLOT_W-1:0]   rd_ptr_reg, rd_ptr_next;

    // result register
    logic                       out_valid_reg, out_valid_next;
    logic [GROUP_W-1:0]         out_grp_reg;
    logic [SLOT_IDX_W-1:0]      out_slot_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic                       out_last_reg;
    logic                       out_load;
    logic [SLOT_IDX_W-1:0]      out_slot_in;
    logic signed [SAMPLE_W-1:0] out_value_in;
    logic                       out_last_in;
    logic                       out_free;

    logic                     accept;
    logic [GROUP_EXT_W-1:0]   grp_ext;
    logic [GROUP_EXT_W-1:0]   grp_sub;
    logic                     grp_ok;
    logic [COUNT_W-1:0]       cnt_raw;
    logic [COUNT_W-1:0]       cnt_look;
    logic [COUNT_W-1:0]       cnt_m1;
    logic [COUNT_W-1:0]       cnt_sat;

    logic               rem_start;
    logic               rem_done;
    logic [COUNT_W-1:0] rem_value;

    assign accept   = items.valid && items.ready;
    assign out_free = !out_valid_reg || results.ready;

    // range check and zero-based row index of the incoming group
    assign grp_ext = GROUP_EXT_W'(items.group_number);
    assign grp_sub = grp_ext - GROUP_EXT_W'(1);
    assign grp_ok  = (items.group_number != '0) && (grp_ext <= GROUP_EXT_W'(GROUP_COUNT));

    // count as seen by this add: restart, and never zero
    assign cnt_raw  = start_reg ? COUNT_RESET : rd_row_reg[COUNT_W-1:0];
    assign cnt_look = (cnt_raw == '0) ? COUNT_RESET : cnt_raw;
    assign cnt_m1   = cnt_look - COUNT_W'(1);
    assign cnt_sat  = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + COUNT_W'(1);

    // divisor is taken at start, in the lookup cycle
    grs_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (rnd_reg),
        .divisor   (cnt_look),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        cnt_next     = cnt_reg;
        hit_next     = hit_reg;
        pos_next     = pos_reg;
        rd_ptr_next  = rd_ptr_reg;
        rem_start    = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = gidx_reg;
        mem_wd       = rd_row_reg;
        mem_re       = 1'b0;
        mem_ra       = grp_ok ? grp_sub[GW-1:0] : '0;
        out_load     = 1'b0;
        out_slot_in  = '0;
        out_value_in = '0;
        out_last_in  = 1'b1;
        items.ready  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_ptr_reg;
                mem_wd = ROW_W'(COUNT_RESET);
                if (clr_ptr_reg == GROUP_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                items.ready = 1'b1;
                if (items.valid)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                rd_ptr_next = '0;
                cnt_next    = cnt_look;
                if (op_reg == OP_READ)
                begin
                    state_next = ST_RD_OUT;
                end
                else if (item_valid_reg && (cnt_look > SLOTS_CNT))
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    // reservoir still filling: slot count-1
                    hit_next   = item_valid_reg;
                    pos_next   = cnt_m1[SLOT_W-1:0];
                    state_next = ST_ADD_WB;
                end
            end
            ST_DIV:
            begin
                if (rem_done)
                begin
                    hit_next   = rem_value < SLOTS_CNT;
                    pos_next   = rem_value[SLOT_W-1:0];
                    state_next = ST_ADD_WB;
                end
            end
            ST_ADD_WB:
            begin
                mem_wd[COUNT_W-1:0] = cnt_sat;
                if (hit_reg)
                begin
                    mem_wd[COUNT_W + SAMPLE_W * pos_reg +: SAMPLE_W] = sample_reg;
                end
                if (out_free)
                begin
                    mem_we     = item_valid_reg;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD_OUT:
            begin
                out_slot_in = SLOT_IDX_W'(rd_ptr_reg);
                out_last_in = rd_ptr_reg == SLOT_LAST;
                if (item_valid_reg)
                begin
                    out_value_in = rd_row_reg[COUNT_W + SAMPLE_W * rd_ptr_reg +: SAMPLE_W];
                end
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (rd_ptr_reg == SLOT_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // group table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            group_ram[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_row_reg <= group_ram[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_ptr_reg   <= clr_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        hit_reg    <= hit_next;
        pos_reg    <= pos_next;
        rd_ptr_reg <= rd_ptr_next;
        if (accept)
        begin
            op_reg         <= items.operation;
            grp_reg        <= items.group_number;
            start_reg      <= items.start_group;
            sample_reg     <= items.sample_value;
            rnd_reg        <= items.random_word;
            item_valid_reg <= grp_ok;
            gidx_reg       <= mem_ra;
        end
        if (out_load)
        begin
            out_grp_reg   <= grp_reg;
            out_slot_reg  <= out_slot_in;
            out_value_reg <= out_value_in;
            out_last_reg  <= out_last_in;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.group_echo  = out_grp_reg;
    assign results.slot_index  = out_slot_reg;
    assign results.slot_value  = out_value_reg;
    assign results.last_result = out_last_reg;

    // remainder results only arrive while the sequencer waits for them
    a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> state_reg == ST_DIV)
        else $error("remainder finished outside the divide state");

    // an add never touches the table for a group outside the range
    a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_ADD_WB) |-> item_valid_reg)
        else $error("table write for an out-of-range group");

    // every accepted item is looked up in the next cycle
    a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOK)
        else $error("accepted item not followed by table lookup");

    // no result is loaded while a stalled word would be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !results.ready) |-> !out_load)
        else $error("result register overwritten while stalled");

endmodule

[sim/grouped_reservoir_sampler_top_tb.sv]
// testbench for the grouped reservoir sampler: directed and random items checked per word
`timescale 1ns / 1ps

module grouped_reservoir_sampler_top_tb;
    import grs_pkg::*;

    localparam int GROUPS = DEF_GROUP_COUNT;
    localparam int SLOTS  = DEF_RESERVOIR_SLOTS;

    // total items to send, and where the idle-free tail begins
    localparam int unsigned ITEM_TARGET = 450;
    localparam int unsigned QUIET_TAIL  = 60;

    // one input word as the sender sees it
    typedef struct packed {
        logic                  operation;
        logic [GROUP_W-1:0]    group_number;
        logic                  start_group;
        logic [SAMPLE_W-1:0]   sample_value;
        logic [RANDOM_W-1:0]   random_word;
    } sampler_item_t;

    // one result word as the receiver sees it
    typedef struct packed {
        logic [GROUP_W-1:0]    group_echo;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [SAMPLE_W-1:0]   slot_value;
        logic                  last_result;
    } slot_word_t;

    logic clk;
    logic rst_n;

    grs_item_if   items_if ();
    grs_result_if results_if ();

    grouped_reservoir_sampler_top #(
        .GROUP_COUNT     (GROUPS),
        .RESERVOIR_SLOTS (SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    // shadow copy of the group table: running counts and reservoir slots
    logic [COUNT_W-1:0]  group_count  [GROUPS];
    logic [SAMPLE_W-1:0] sample_store [GROUPS*SLOTS];

    // words still owed by the block, oldest first
    slot_word_t  owed_words[$];

    int unsigned items_sent;
    int unsigned mismatch_count;
    bit          idle_on;
    int unsigned stall_left;

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // -----------------------------------------------------------------
    // shadow model of the sampler
    // -----------------------------------------------------------------

    // table contents after the clearing pass: count 1, all slots zero
    function automatic void clear_shadow_table();
        for (int g = 0; g < GROUPS; g++)
        begin
            group_count[g] = COUNT_RESET;
        end
        for (int k = 0; k < GROUPS*SLOTS; k++)
        begin
            sample_store[k] = '0;
        end
    endfunction

    // apply one accepted item to the shadow table and queue the words it owes
    function automatic void predict_words(input sampler_item_t it);
        logic [COUNT_W-1:0] cnt;
        logic [COUNT_W-1:0] pick;
        int unsigned        row;
        bit                 in_range;
        slot_word_t         w;
        in_range = (it.group_number >= 1) && (it.group_number <= GROUPS);
        row      = in_range ? it.group_number - 1 : 0;
        if (it.operation == OP_ADD)
        begin
            if (in_range)
            begin
                // a new group restarts the count before the sample lands
                if (it.start_group)
                begin
                    group_count[row] = COUNT_RESET;
                end
                cnt = group_count[row];
                if (cnt == '0)
                begin
                    cnt = COUNT_RESET;
                end
                if (cnt <= SLOTS)
                begin
                    // reservoir still filling: sample goes to slot count-1
                    sample_store[row*SLOTS + cnt - 1] = it.sample_value;
                end
                else
                begin
                    // full reservoir: random word mod count, keep if it hits a slot
                    pick = {1'b0, it.random_word} % cnt;
                    if (pick < SLOTS)
                    begin
                        sample_store[row*SLOTS + pick] = it.sample_value;
                    end
                end
                // count holds at its top value instead of wrapping
                if (cnt != COUNT_MAX)
                begin
                    cnt = cnt + 1;
                end
                group_count[row] = cnt;
            end
            w.group_echo  = it.group_number;
            w.slot_index  = '0;
            w.slot_value  = '0;
            w.last_result = 1'b1;
            owed_words.push_back(w);
        end
        else
        begin
            // read streams every slot; groups out of range read as zero
            for (int s = 0; s < SLOTS; s++)
            begin
                w.group_echo  = it.group_number;
                w.slot_index  = s[SLOT_IDX_W-1:0];
                w.slot_value  = in_range ? sample_store[row*SLOTS + s] : '0;
                w.last_result = (s == SLOTS - 1);
                owed_words.push_back(w);
            end
        end
    endfunction

    // -----------------------------------------------------------------
    // stimulus helpers
    // -----------------------------------------------------------------

    function automatic sampler_item_t make_item(input logic op, input int unsigned grp,
                                                input logic start,
                                                input logic [SAMPLE_W-1:0] sample,
                                                input logic [RANDOM_W-1:0] rnd);
        sampler_item_t it;
        it.operation    = op;
        it.group_number = grp[GROUP_W-1:0];
        it.start_group  = start;
        it.sample_value = sample;
        it.random_word  = rnd;
        return it;
    endfunction

    // samples lean toward the signed extremes now and then
    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // small random words land inside the reservoir far more often
    function automatic logic [RANDOM_W-1:0] random_pick_word();
        case ($urandom_range(0, 5))
            0, 1:    return RANDOM_W'($urandom_range(0, 15));
            2:       return '1;
            default: return RANDOM_W'($urandom);
        endcase
    endfunction

    // send one word: optional sender gap, then hold valid until accepted.
    // valid is left high on return; the next call lowers it only for a sender gap, and the drain lowers it
    task automatic send_word(input sampler_item_t it);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            items_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        items_if.valid        <= 1'b1;
        items_if.operation    <= it.operation;
        items_if.group_number <= it.group_number;
        items_if.start_group  <= it.start_group;
        items_if.sample_value <= it.sample_value;
        items_if.random_word  <= it.random_word;
        @(posedge clk);
        while (!items_if.ready)
        begin
            @(posedge clk);
        end
        predict_words(it);
        items_sent++;
    endtask

    // -----------------------------------------------------------------
    // receiver: ready with random stall bursts
    // -----------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            stall_left       <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            // stall burst: ready low while stall_left counts down
            results_if.ready <= 1'b0;
            stall_left       <= $urandom_range(0, 14);
        end
        else
        begin
            results_if.ready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------
    // result checker: each accepted word against the oldest owed word
    // -----------------------------------------------------------------

    always @(posedge clk)
    begin : check_word
        slot_word_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (owed_words.size() == 0)
            begin
                $error("unexpected result word: group_echo %0d slot_index %0d",
                       results_if.group_echo, results_if.slot_index);
                mismatch_count++;
            end
            else
            begin
                want = owed_words.pop_front();
                if (results_if.group_echo !== want.group_echo)
                begin
                    $error("group_echo: expected %0d, actual %0d",
                           want.group_echo, results_if.group_echo);
                    mismatch_count++;
                end
                if (results_if.slot_index !== want.slot_index)
                begin
                    $error("slot_index: expected %0d, actual %0d",
                           want.slot_index, results_if.slot_index);
                    mismatch_count++;
                end
                if (results_if.slot_value !== want.slot_value)
                begin
                    $error("slot_value: expected %0d, actual %0d",
                           $signed(want.slot_value), $signed(results_if.slot_value));
                    mismatch_count++;
                end
                if (results_if.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, actual %0d",
                           want.last_result, results_if.last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // -----------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------

    // untouched groups read back as zero after the clearing pass
    task automatic test_cleared_table();
        send_word(make_item(OP_READ, 1, 1'b0, '0, '0));
        send_word(make_item(OP_READ, GROUPS, 1'b0, '0, '0));
        send_word(make_item(OP_READ, 513, 1'b0, '0, '0));
    endtask

    // never-started group fills slot 0 upward, then replacement by random word
    task automatic test_fill_and_replace();
        send_word(make_item(OP_ADD, 1, 1'b0, {1'b1, {(SAMPLE_W-1){1'b0}}}, '0));
        send_word(make_item(OP_ADD, 1, 1'b0, {1'b0, {(SAMPLE_W-1){1'b1}}}, '1));
        send_word(make_item(OP_ADD, 1, 1'b0, '0, '0));
        send_word(make_item(OP_ADD, 1, 1'b0, '1, '1));
        // count 5: word 0 lands in slot 0
        send_word(make_item(OP_ADD, 1, 1'b0, 64'h0123_4567_89ab_cdef, '0));
        // count 6: all-ones word mod 6 is 1
        send_word(make_item(OP_ADD, 1, 1'b0, 64'hfedc_ba98_7654_3210, '1));
        send_word(make_item(OP_READ, 1, 1'b0, '0, '0));
    endtask

    // start flag restarts the count, so that add refills slot 0
    task automatic test_group_restart();
        send_word(make_item(OP_ADD, GROUPS, 1'b1, 64'd11, '0));
        send_word(make_item(OP_ADD, GROUPS, 1'b0, 64'd22, '0));
        send_word(make_item(OP_ADD, GROUPS, 1'b1, 64'd33, '1));
        send_word(make_item(OP_READ, GROUPS, 1'b0, '0, '0));
    endtask

    // groups 0 and above the table change nothing; reads ignore extra fields
    task automatic test_out_of_range();
        send_word(make_item(OP_ADD, 0, 1'b1, '1, '0));
        send_word(make_item(OP_ADD, 2047, 1'b0, 64'd5, '1));
        send_word(make_item(OP_ADD, GROUPS + 1, 1'b1, 64'd7, '0));
        send_word(make_item(OP_READ, 0, 1'b1, '1, '1));
        send_word(make_item(OP_READ, 2047, 1'b1, {1'b0, {(SAMPLE_W-1){1'b1}}}, '1));
    endtask

    // mostly well-formed add runs, most followed by a read, with noise mixed in;
    // idling stops for the last stretch
    task automatic test_random_sequences();
        int unsigned grp;
        int unsigned adds;
        logic        fresh;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent + QUIET_TAIL >= ITEM_TARGET)
            begin
                idle_on = 1'b0;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any field value at all
                send_word(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 2047),
                                    1'($urandom_range(0, 1)), {$urandom, $urandom},
                                    RANDOM_W'($urandom)));
            end
            else
            begin
                // a small pool keeps counts climbing; sometimes any group or a bad one
                case ($urandom_range(0, 9))
                    0:       grp = $urandom_range(1, GROUPS);
                    1:       grp = $urandom_range(0, 1) ? 0 : $urandom_range(GROUPS + 1, 2047);
                    default: grp = $urandom_range(1, 8);
                endcase
                fresh = ($urandom_range(0, 3) != 0);
                adds  = $urandom_range(1, 12);
                for (int k = 0; k < adds; k++)
                begin
                    send_word(make_item(OP_ADD, grp, (k == 0) && fresh,
                                        random_sample(), random_pick_word()));
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    send_word(make_item(OP_READ, grp, 1'($urandom_range(0, 1)),
                                        random_sample(), random_pick_word()));
                end
            end
        end
    endtask

    // -----------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------

    initial
    begin
        int unsigned waited;
        rst_n                 = 1'b0;
        items_if.valid        = 1'b0;
        items_if.operation    = OP_ADD;
        items_if.group_number = '0;
        items_if.start_group  = 1'b0;
        items_if.sample_value = '0;
        items_if.random_word  = '0;
        items_sent            = 0;
        mismatch_count        = 0;
        idle_on               = 1'b1;
        clear_shadow_table();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // the clearing pass holds items.ready low; send_word waits it out
        test_cleared_table();
        test_fill_and_replace();
        test_group_restart();
        test_out_of_range();
        test_random_sequences();
        items_if.valid <= 1'b0;

        // drain every owed word, then keep running to catch any stray words
        waited = 0;
        while (owed_words.size() != 0 && waited < 100_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);

        if (owed_words.size() != 0)
        begin
            $error("%0d result words never arrived", owed_words.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/grs_pkg.sv
rtl/grs_if.sv
rtl/grs_rem.sv
rtl/grouped_reservoir_sampler_top.sv
sim/grouped_reservoir_sampler_top_tb.sv
